### rtl/assert_macros.svh
// Assertion macros used by software_timer_pool.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define STP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define STP_ASSERT(lbl, clk, rstn, prop)
`define STP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

### rtl/stp_pkg.sv
// Types and constants of the software timer pool.
// No dependencies.
`default_nettype none
package stp_pkg;
  localparam int STP_NUM_TIMERS = 8;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] period_ms;
    logic               periodic;
    logic [COUNT_W-1:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic               active;
    logic               repeat_mode;
    logic [COUNT_W-1:0] period;
    logic [COUNT_W-1:0] elapsed;
  } slot_t;
endpackage
`default_nettype wire

### rtl/stp_if.sv
// Request and result channels of the timer pool.
// Depends on stp_pkg.
`default_nettype none
interface stp_in_if import stp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] period_ms;
  logic               periodic;
  logic [COUNT_W-1:0] elapsed_ms;
  modport source (output valid, mode, slot, period_ms, periodic, elapsed_ms, input ready);
  modport sink   (input valid, mode, slot, period_ms, periodic, elapsed_ms, output ready);
endinterface

interface stp_out_if import stp_pkg::*;;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot_out;
  modport source (output valid, ok, slot_out, input ready);
  modport sink   (input valid, ok, slot_out, output ready);
endinterface
`default_nettype wire

### rtl/stp_cell.sv
// One timer slot of the rotating chain; loads its neighbour's state on shift.
// Depends on stp_pkg.
`default_nettype none
module stp_cell import stp_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   shift_i,
  input  slot_t d_i,
  output slot_t q_o
);
  slot_t st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (shift_i) begin
      st_q <= d_i;
    end
  end

  assign q_o = st_q;
endmodule
`default_nettype wire

### rtl/stp_slot_op.sv
// Applies the current request to the slot passing the head of the chain.
// Depends on stp_pkg.
`default_nettype none
module stp_slot_op import stp_pkg::*; (
  input  cmd_t              cmd_i,
  input  wire [SLOT_W-1:0]  idx_i,
  input  wire               claimed_i,
  input  slot_t             st_i,
  output slot_t             st_o,
  output logic              hit_o
);
  logic              sel;
  logic [COUNT_W:0]  sum;

  assign sel = (cmd_i.slot == idx_i);
  assign sum = {1'b0, st_i.elapsed} + {1'b0, cmd_i.elapsed_ms};

  always_comb begin
    st_o  = st_i;
    hit_o = 1'b0;
    case (cmd_i.mode)
      MODE_TICK: begin
        if (st_i.active) begin
          st_o.elapsed = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end
      end
      MODE_START: begin
        if (!st_i.active && !claimed_i) begin
          st_o.active      = 1'b1;
          st_o.repeat_mode = cmd_i.periodic;
          st_o.period      = cmd_i.period_ms;
          st_o.elapsed     = '0;
          hit_o            = 1'b1;
        end
      end
      MODE_STOP: begin
        if (sel) begin
          st_o.active = 1'b0;
        end
      end
      MODE_QUERY: begin
        if (sel && st_i.active && (st_i.elapsed >= st_i.period)) begin
          if (st_i.repeat_mode) begin
            st_o.elapsed = '0;
          end else begin
            st_o.active = 1'b0;
          end
          hit_o = 1'b1;
        end
      end
      default: begin
        st_o  = st_i;
        hit_o = 1'b0;
      end
    endcase
  end
endmodule
`default_nettype wire

### rtl/software_timer_pool.sv
// Software timer pool: a ring of timer slots rotated past one update unit.
// Depends on stp_pkg, stp_if, stp_cell, stp_slot_op and assert_macros.svh.
//
// Usage:
//   in_i carries requests: tick (add elapsed_ms to every running timer,
//   saturating), start (claim the lowest free slot), stop (free a slot) and
//   query (report and consume a match of one slot). out_o returns one result
//   per request: ok and, for a successful start, the claimed slot.
// Timing:
//   A request rotates the whole ring once, one slot per cycle through the
//   update unit (the final step waits while an earlier result is held), and
//   its result is registered at the last step. The next request is taken in
//   the cycle of the last step, and not while the ring is still rotating.
// Stalls:
//   A request may be accepted while the previous result waits on out_o. If
//   that result is still held when the ring reaches its final step, the ring
//   pauses there until the result is taken.
// Reset:
//   All slots clear to inactive; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module software_timer_pool import stp_pkg::*; #(
  parameter int NUM_TIMERS = STP_NUM_TIMERS
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o
);
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  cmd_t              cmd_q;
  logic              busy_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              hit_acc_q;
  logic [SLOT_W-1:0] slot_acc_q;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [SLOT_W-1:0] out_slot_q;

  slot_t             cell_q [NUM_TIMERS];
  slot_t             head_d;
  logic              hit;
  logic              last;
  logic              out_free;
  logic              step;
  logic              accept;
  logic [SLOT_W-1:0] idx;
  logic              start_hit;

  assign last      = (cnt_q == LAST_IDX);
  assign out_free  = !out_valid_q || out_o.ready;
  assign step      = busy_q && (!last || out_free);
  assign in_i.ready = !busy_q || (last && step);
  assign accept    = in_i.valid && in_i.ready;
  assign idx       = SLOT_W'(cnt_q);
  assign start_hit = hit && (cmd_q.mode == MODE_START);

  stp_slot_op u_op (
    .cmd_i     (cmd_q),
    .idx_i     (idx),
    .claimed_i (hit_acc_q),
    .st_i      (cell_q[0]),
    .st_o      (head_d),
    .hit_o     (hit)
  );

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    slot_t d;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign d = head_d;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    stp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .d_i     (d),
      .q_o     (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      hit_acc_q   <= 1'b0;
      slot_acc_q  <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_slot_q  <= '0;
      cmd_q       <= '0;
    end else begin
      if (step) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
      if (accept) begin
        busy_q     <= 1'b1;
        hit_acc_q  <= 1'b0;
        slot_acc_q <= '0;
        cmd_q.mode       <= mode_e'(in_i.mode);
        cmd_q.slot       <= in_i.slot;
        cmd_q.period_ms  <= in_i.period_ms;
        cmd_q.periodic   <= in_i.periodic;
        cmd_q.elapsed_ms <= in_i.elapsed_ms;
      end else if (step) begin
        hit_acc_q <= hit_acc_q | hit;
        if (start_hit) begin
          slot_acc_q <= idx;
        end
        if (last) begin
          busy_q <= 1'b0;
        end
      end
      if (step && last) begin
        out_valid_q <= 1'b1;
        out_ok_q    <= hit_acc_q | hit;
        out_slot_q  <= start_hit ? idx : slot_acc_q;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.ok       = out_ok_q;
  assign out_o.slot_out = out_slot_q;

  `STP_ASSERT(a_idle_aligned, clk_i, rst_ni, !busy_q |-> (cnt_q == '0))
  `STP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_q)
  `STP_ASSERT(a_result_from_run, clk_i, rst_ni, $rose(out_valid_q) |-> $past(busy_q))
  `STP_ASSERT(a_slot_needs_ok, clk_i, rst_ni, (out_valid_q && out_slot_q != '0) |-> out_ok_q)
endmodule
`default_nettype wire

### tb/sv/software_timer_pool_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of software_timer_pool: directed table, then random requests.
// Depends on stp_pkg, stp_if and the RTL of the timer pool.
module software_timer_pool_tb;
  import stp_pkg::*;

  localparam int ITEMS_PER_PHASE = 112;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 4 * STP_NUM_TIMERS;
  localparam int CYCLE_LIMIT     = 100000;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
  } pool_res_t;

  typedef struct {
    cmd_t      cmd;
    logic      typed;
    pool_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  stp_in_if  req_bus ();
  stp_out_if rsp_bus ();

  software_timer_pool DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_bus),
    .out_o  (rsp_bus)
  );

  slot_t     model_slots [STP_NUM_TIMERS];
  pool_res_t pending_replies [$];
  dir_row_t  directed_rows [$];
  int        send_idle_pct;
  int        stall_pct;
  int        hold_asks;
  int        hold_taken;
  int        hold_left;
  int        errors;
  int        cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the model pool and returns its reply.
  function automatic pool_res_t timer_pool_apply(cmd_t c);
    pool_res_t        r;
    logic [COUNT_W:0] sum;
    logic             found;
    int               idx;
    r     = '0;
    found = 1'b0;
    idx   = int'(c.slot);
    case (c.mode)
      MODE_TICK: begin
        for (int k = 0; k < STP_NUM_TIMERS; k++) begin
          if (model_slots[k].active) begin
            sum = {1'b0, model_slots[k].elapsed} + {1'b0, c.elapsed_ms};
            model_slots[k].elapsed = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
          end
        end
      end
      MODE_START: begin
        for (int k = 0; k < STP_NUM_TIMERS; k++) begin
          if (!found && !model_slots[k].active) begin
            model_slots[k].repeat_mode = c.periodic;
            model_slots[k].period      = c.period_ms;
            model_slots[k].elapsed     = '0;
            model_slots[k].active      = 1'b1;
            r.ok       = 1'b1;
            r.slot_out = SLOT_W'(k);
            found      = 1'b1;
          end
        end
      end
      MODE_STOP: begin
        if (idx < STP_NUM_TIMERS) model_slots[idx].active = 1'b0;
      end
      default: begin
        if (idx < STP_NUM_TIMERS) begin
          if (model_slots[idx].active &&
              model_slots[idx].elapsed >= model_slots[idx].period) begin
            if (model_slots[idx].repeat_mode) model_slots[idx].elapsed = '0;
            else model_slots[idx].active = 1'b0;
            r.ok = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(mode_e m, int slot, int per, bit rep, int ms,
                                  bit typed, bit ok, int sout);
    dir_row_t row;
    row.cmd.mode          = m;
    row.cmd.slot          = SLOT_W'(slot);
    row.cmd.period_ms     = COUNT_W'(per);
    row.cmd.periodic      = rep;
    row.cmd.elapsed_ms    = COUNT_W'(ms);
    row.typed             = typed;
    row.want.ok           = ok;
    row.want.slot_out     = SLOT_W'(sout);
    directed_rows.push_back(row);
  endfunction

  function automatic cmd_t random_request();
    cmd_t c;
    int   roll;
    roll = $urandom_range(99);
    if (roll < 30)      c.mode = MODE_TICK;
    else if (roll < 50) c.mode = MODE_START;
    else if (roll < 65) c.mode = MODE_STOP;
    else                c.mode = MODE_QUERY;
    if ($urandom_range(99) < 85) c.slot = SLOT_W'($urandom_range(STP_NUM_TIMERS - 1));
    else c.slot = SLOT_W'($urandom_range((1 << SLOT_W) - 1, STP_NUM_TIMERS));
    roll = $urandom_range(99);
    if (roll < 70)      c.period_ms = COUNT_W'($urandom_range(100));
    else if (roll < 95) c.period_ms = COUNT_W'($urandom);
    else                c.period_ms = COUNT_MAX;
    c.periodic = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < 60)      c.elapsed_ms = COUNT_W'($urandom_range(40));
    else if (roll < 85) c.elapsed_ms = COUNT_W'($urandom);
    else if (roll < 92) c.elapsed_ms = COUNT_MAX;
    else                c.elapsed_ms = '0;
    return c;
  endfunction

  // Offers one request, waits for it to be taken, then records its reply.
  task automatic send_request(input cmd_t c, input logic typed, input pool_res_t want);
    pool_res_t got;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.mode       <= c.mode;
    req_bus.slot       <= c.slot;
    req_bus.period_ms  <= c.period_ms;
    req_bus.periodic   <= c.periodic;
    req_bus.elapsed_ms <= c.elapsed_ms;
    do @(posedge clk); while (!req_bus.ready);
    got = timer_pool_apply(c);
    pending_replies.push_back(typed ? want : got);
  endtask

  // Reply side: checks every reply taken and drives ready.
  initial begin
    pool_res_t want;
    rsp_bus.ready = 1'b0;
    hold_taken    = 0;
    hold_left     = 0;
    errors        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply ok=%0b slot_out=%0d", $time,
                   rsp_bus.ok, rsp_bus.slot_out);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_bus.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b", $time,
                     want.ok, rsp_bus.ok);
            errors++;
          end
          if (rsp_bus.slot_out !== want.slot_out) begin
            $display("%0t: slot_out mismatch: expected %0d, actual %0d", $time,
                     want.slot_out, rsp_bus.slot_out);
            errors++;
          end
        end
      end
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.mode       = MODE_TICK;
    req_bus.slot       = '0;
    req_bus.period_ms  = '0;
    req_bus.periodic   = 1'b0;
    req_bus.elapsed_ms = '0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    hold_asks          = 0;
    for (int k = 0; k < STP_NUM_TIMERS; k++) model_slots[k] = '0;

    // mode, slot, period, periodic, elapsed, typed, ok, slot_out
    add_row(MODE_TICK,  15, 'hFFFF, 1, 'hFFFF, 1, 0, 0);  // tick with no timer running
    add_row(MODE_QUERY,  0, 0,      0, 0,      1, 0, 0);  // inactive slot
    add_row(MODE_STOP,  15, 'hFFFF, 1, 'hFFFF, 1, 0, 0);  // out of range
    add_row(MODE_QUERY, 15, 0,      0, 0,      1, 0, 0);  // out of range
    add_row(MODE_START,  0, 0,      1, 0,      1, 1, 0);  // zero period, periodic
    add_row(MODE_QUERY,  0, 0,      0, 0,      1, 1, 0);
    add_row(MODE_QUERY,  0, 0,      0, 0,      1, 1, 0);
    add_row(MODE_START,  9, 'hFFFF, 0, 'hFFFF, 1, 1, 1);
    add_row(MODE_START,  0, 5,      0, 0,      1, 1, 2);
    add_row(MODE_START,  0, 10,     1, 0,      1, 1, 3);
    add_row(MODE_START,  0, 1,      0, 0,      1, 1, 4);
    add_row(MODE_START,  0, 2,      1, 0,      1, 1, 5);
    add_row(MODE_START,  0, 3,      0, 0,      1, 1, 6);
    add_row(MODE_START,  0, 4,      1, 0,      1, 1, 7);
    add_row(MODE_START,  0, 7,      1, 0,      1, 0, 0);  // pool full
    add_row(MODE_TICK,   0, 0,      0, 'hFFFF, 1, 0, 0);
    add_row(MODE_TICK,   0, 0,      0, 1,      1, 0, 0);  // saturates
    add_row(MODE_QUERY,  1, 0,      0, 0,      1, 1, 0);  // one-shot ends
    add_row(MODE_QUERY,  1, 0,      0, 0,      1, 0, 0);
    add_row(MODE_STOP,   2, 0,      0, 0,      1, 0, 0);
    add_row(MODE_STOP,   2, 0,      0, 0,      1, 0, 0);  // already stopped
    add_row(MODE_START,  0, 100,    1, 0,      1, 1, 1);  // lowest free slot
    add_row(MODE_QUERY,  3, 0,      0, 0,      0, 0, 0);
    add_row(MODE_QUERY,  3, 0,      0, 0,      0, 0, 0);
    add_row(MODE_TICK,  12, 'hFFFF, 1, 0,      1, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // no idling, with one long hold-off on the reply side
    hold_asks <= hold_asks + 1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, '0);
    send_idle_pct = 63;
    stall_pct     = 0;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, '0);
    send_idle_pct = 0;
    stall_pct     = 63;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, '0);
    send_idle_pct = 14;
    stall_pct     = 14;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request(), 1'b0, '0);

    req_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
